FILE: design/lfusa_pkg.sv
`timescale 1ns / 1ps

package lfusa_pkg;

  localparam int TagW     = 31;
  localparam int CntW     = 16;
  localparam int MissW    = 32;
  localparam int LineOutW = 4;

  localparam int LinesDef = 16;
  localparam int WaysDef  = 4;
  localparam int SetsDef  = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICT,
    ST_WRITE,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic                was_hit;
    logic [LineOutW-1:0] line_used;
    logic [MissW-1:0]    miss_total;
  } res_t;

endpackage

FILE: design/lfusa_if.sv
`timescale 1ns / 1ps

interface lfusa_req_if import lfusa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TagW-1:0] ref_tag;

  modport source (output valid, output ref_tag, input ready);
  modport sink (input valid, input ref_tag, output ready);
endinterface

interface lfusa_rsp_if import lfusa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                was_hit;
  logic [LineOutW-1:0] line_used;
  logic [MissW-1:0]    miss_total;

  modport source (output valid, output was_hit, output line_used, output miss_total,
                  input ready);
  modport sink (input valid, input was_hit, input line_used, input miss_total,
                output ready);
endinterface

FILE: design/lfusa_mem.sv
`timescale 1ns / 1ps

module lfusa_mem #(
  parameter int Depth = 16,
  parameter int Width = 47,
  parameter int AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/lfusa_seq.sv
`timescale 1ns / 1ps

module lfusa_seq import lfusa_pkg::*; #(
  parameter int LINES = LinesDef,
  parameter int WAYS  = WaysDef,
  parameter int SETS  = SetsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [TagW-1:0] in_tag_i,
  output logic            in_ready_o,
  output logic            done_o,
  input  logic            take_i,
  output res_t            res_o
);

  localparam int IdxW  = $clog2(LINES);
  localparam int IdxCW = $clog2(LINES + 1);
  localparam int WcW   = $clog2(WAYS + 1);
  localparam int SeqW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int LnW   = $clog2(SETS * WAYS + LINES + 1);
  localparam int MemW  = TagW + CntW;

  seq_state_e state_q, state_d;

  logic [TagW-1:0]  tag_q, tag_d;
  logic [IdxCW-1:0] idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  pidx_q, pidx_d;
  logic [WcW-1:0]   way_q, way_d;
  logic             any_q, any_d;
  logic [CntW-1:0]  least_q, least_d;
  logic [CntW-1:0]  wcnt_q, wcnt_d;
  logic [IdxW-1:0]  line_q, line_d;
  logic             hit_q, hit_d;
  logic [SeqW-1:0]  seq_q, seq_d;
  logic [MissW-1:0] miss_q, miss_d;
  logic [LINES-1:0] valid_q, valid_d;

  logic             mem_we;
  logic             mem_re;
  logic [IdxW-1:0]  mem_raddr;
  logic [MemW-1:0]  mem_rdata;
  logic [TagW-1:0]  rd_tag;
  logic [CntW-1:0]  rd_cnt;

  logic [LnW-1:0]   base;
  logic [LnW-1:0]   nway;
  logic [LnW-1:0]   vict_ln;
  logic             no_set;
  logic             free_found;
  logic [IdxW-1:0]  free_ln;
  logic             scan_rd;
  logic             scan_hit;
  logic             scan_miss;
  logic             vict_rd;

  lfusa_mem #(
    .Depth (LINES),
    .Width (MemW),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (line_q),
    .wdata_i ({tag_q, wcnt_q}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_tag = mem_rdata[CntW +: TagW];
  assign rd_cnt = mem_rdata[CntW-1:0];

  // The fill set follows the reference sequence number, not the tag.
  assign base    = LnW'(seq_q) * LnW'(WAYS);
  assign no_set  = (base >= LnW'(LINES));
  assign nway    = no_set ? '0 :
                   ((LnW'(LINES) - base) < LnW'(WAYS)) ? (LnW'(LINES) - base) : LnW'(WAYS);
  assign vict_ln = base + LnW'(way_q);

  always_comb begin
    logic [LnW-1:0] ln;
    free_found = 1'b0;
    free_ln    = '0;
    for (int w = 0; w < WAYS; w++) begin
      ln = base + LnW'(w);
      if (!free_found && ln < LnW'(LINES) && !valid_q[ln[IdxW-1:0]]) begin
        free_found = 1'b1;
        free_ln    = ln[IdxW-1:0];
      end
    end
  end

  assign scan_rd   = (state_q == ST_SCAN) && (idx_q < IdxCW'(LINES));
  assign scan_hit  = (state_q == ST_SCAN) && pend_q && valid_q[pidx_q] && (rd_tag == tag_q);
  assign scan_miss = (state_q == ST_SCAN) && pend_q && !scan_hit &&
                     (pidx_q == IdxW'(LINES - 1));
  assign vict_rd   = (state_q == ST_VICT) && (LnW'(way_q) < nway);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          state_d = ST_WRITE;
        end else if (scan_miss) begin
          if (no_set) begin
            state_d = ST_DONE;
          end else if (free_found) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_VICT;
          end
        end
      end
      ST_VICT: begin
        if (!vict_rd && pend_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tag_d     = tag_q;
    idx_d     = idx_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    way_d     = way_q;
    any_d     = any_q;
    least_d   = least_q;
    wcnt_d    = wcnt_q;
    line_d    = line_q;
    hit_d     = hit_q;
    seq_d     = seq_q;
    miss_d    = miss_q;
    valid_d   = valid_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx_q[IdxW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tag_d = in_tag_i;
          idx_d = '0;
        end
      end
      ST_SCAN: begin
        // Read of one line per cycle; the tag of the previous read is compared.
        mem_re = scan_rd;
        pend_d = scan_rd;
        pidx_d = idx_q[IdxW-1:0];
        if (scan_rd) begin
          idx_d = idx_q + 1'b1;
        end
        if (scan_hit) begin
          pend_d = 1'b0;
          hit_d  = 1'b1;
          line_d = pidx_q;
          wcnt_d = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
        end else if (scan_miss) begin
          hit_d  = 1'b0;
          miss_d = (miss_q == '1) ? miss_q : miss_q + 1'b1;
          wcnt_d = CntW'(1);
          way_d  = '0;
          any_d  = 1'b0;
          if (no_set) begin
            line_d = '0;
          end else if (free_found) begin
            line_d = free_ln;
          end
        end
      end
      ST_VICT: begin
        // Every way of the set is valid here; keep the first least count.
        mem_re    = vict_rd;
        mem_raddr = vict_ln[IdxW-1:0];
        pend_d    = vict_rd;
        pidx_d    = vict_ln[IdxW-1:0];
        if (vict_rd) begin
          way_d = way_q + 1'b1;
        end
        if (pend_q && (!any_q || rd_cnt < least_q)) begin
          any_d   = 1'b1;
          least_d = rd_cnt;
          line_d  = pidx_q;
        end
      end
      ST_WRITE: begin
        mem_we          = 1'b1;
        valid_d[line_q] = 1'b1;
      end
      ST_DONE: begin
        if (take_i) begin
          seq_d = (seq_q == SeqW'(SETS - 1)) ? '0 : seq_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign done_o           = (state_q == ST_DONE);
  assign res_o.was_hit    = hit_q;
  assign res_o.line_used  = LineOutW'(line_q);
  assign res_o.miss_total = miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      any_q   <= 1'b0;
      hit_q   <= 1'b0;
      seq_q   <= '0;
      miss_q  <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      any_q   <= any_d;
      hit_q   <= hit_d;
      seq_q   <= seq_d;
      miss_q  <= miss_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    way_q   <= way_d;
    least_q <= least_d;
    wcnt_q  <= wcnt_d;
    line_q  <= line_d;
  end

`ifndef SYNTH
  a_hit_line_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && hit_q) |-> valid_q[line_q])
    else $error("hit reported on an invalid line");

  a_miss_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> (miss_q >= $past(miss_q)))
    else $error("miss counter went down");

  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q <= SeqW'(SETS - 1))
    else $error("sequence number out of range");

  a_vict_all_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vict_rd |-> valid_q[vict_ln[IdxW-1:0]])
    else $error("victim search on a set with a free way");

  a_valid_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WRITE) |=> (valid_q == $past(valid_q)))
    else $error("valid bits changed outside a write");
`endif

endmodule

FILE: design/lfu_set_assoc_cache_sim.sv
`timescale 1ns / 1ps

// Channel  Dir  Modport  Payload
// req_i    in   sink     ref_tag[30:0]
// rsp_o    out  source   was_hit, line_used[3:0], miss_total[31:0]
//
// One reference at a time. The tag scan reads one line per cycle from the line
// memory and stops at the first matching line on a hit. A miss scans every line
// and, when the set has no free way, also reads the set's ways to pick a victim.
// Reset clears the valid bits, the sequence number and the miss counter at once.
// A result waits in the output register; a new reference is taken meanwhile, and
// its own result holds the sequencer only while the register is still full.
module lfu_set_assoc_cache_sim import lfusa_pkg::*; #(
  parameter int LINES = LinesDef,
  parameter int WAYS  = WaysDef,
  parameter int SETS  = SetsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  lfusa_req_if.sink   req_i,
  lfusa_rsp_if.source rsp_o
);

  logic done;
  logic take;
  res_t res;
  res_t res_q;
  logic ovalid_q, ovalid_d;

  lfusa_seq #(
    .LINES (LINES),
    .WAYS  (WAYS),
    .SETS  (SETS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_tag_i   (req_i.ref_tag),
    .in_ready_o (req_i.ready),
    .done_o     (done),
    .take_i     (take),
    .res_o      (res)
  );

  // A finished result moves into the output register once it is free or draining.
  assign take = done && (!ovalid_q || rsp_o.ready);

  always_comb begin
    ovalid_d = ovalid_q;
    if (take) begin
      ovalid_d = 1'b1;
    end else if (rsp_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid      = ovalid_q;
  assign rsp_o.was_hit    = res_q.was_hit;
  assign rsp_o.line_used  = res_q.line_used;
  assign rsp_o.miss_total = res_q.miss_total;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lfusa_pkg::*;

  localparam int Lines      = LinesDef;
  localparam int Ways       = WaysDef;
  localparam int Sets       = SetsDef;
  localparam int PoolSize   = 24;
  localparam int HotSize    = 6;
  localparam int HotRefs    = 200;
  localparam int StallLimit = 4000;
  localparam int DrainWait  = 40;

  logic clk_i;
  logic rst_ni;

  lfusa_req_if req_if ();
  lfusa_rsp_if rsp_if ();

  lfu_set_assoc_cache_sim i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Shadow copy of the cache contents.
  bit [TagW-1:0]  line_tag   [Lines];
  bit             line_valid [Lines];
  bit [CntW-1:0]  use_cnt    [Lines];
  bit [MissW-1:0] miss_cnt;
  int             fill_set;

  res_t           pending_results [$];
  logic [TagW-1:0] tag_pool [PoolSize];

  int src_idle_pct;
  int snk_stall_pct;
  int err_cnt;
  int ref_cnt;
  int hit_cnt;
  int stall_cycles;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Looks up one tag, updates the shadow cache and returns the expected result.
  function automatic res_t lfu_lookup(input logic [TagW-1:0] tag);
    res_t          r;
    bit            found;
    int            sel_line;
    int            base;
    int            free_line;
    int            victim;
    int            idx;
    bit [CntW-1:0] least;
    found    = 1'b0;
    sel_line = 0;
    for (int i = 0; i < Lines; i++) begin
      if (!found && line_valid[i] && line_tag[i] == tag) begin
        found    = 1'b1;
        sel_line = i;
      end
    end
    ref_cnt++;
    if (found) begin
      hit_cnt++;
      if (use_cnt[sel_line] != '1) use_cnt[sel_line] = use_cnt[sel_line] + 1'b1;
    end else begin
      if (miss_cnt != '1) miss_cnt = miss_cnt + 1'b1;
      base      = fill_set * Ways;
      free_line = -1;
      victim    = -1;
      least     = '0;
      // The first free way wins; otherwise the least-used way, lowest way on a tie.
      for (int w = 0; w < Ways; w++) begin
        idx = base + w;
        if (idx < Lines && free_line < 0) begin
          if (!line_valid[idx]) begin
            free_line = idx;
          end else if (victim < 0 || use_cnt[idx] < least) begin
            victim = idx;
            least  = use_cnt[idx];
          end
        end
      end
      if (free_line >= 0) sel_line = free_line;
      else if (victim >= 0) sel_line = victim;
      if (free_line >= 0 || victim >= 0) begin
        line_tag[sel_line]   = tag;
        line_valid[sel_line] = 1'b1;
        use_cnt[sel_line]    = CntW'(1);
      end
    end
    fill_set   = (fill_set + 1) % Sets;
    r.was_hit    = found;
    r.line_used  = sel_line[LineOutW-1:0];
    r.miss_total = miss_cnt;
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    res_t exp_r;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no reference pending: was_hit %0d line_used %0d miss_total %0d",
                 rsp_if.was_hit, rsp_if.line_used, rsp_if.miss_total);
          err_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (rsp_if.was_hit !== exp_r.was_hit) begin
            $error("was_hit: expected %0d, got %0d", exp_r.was_hit, rsp_if.was_hit);
            err_cnt++;
          end
          if (rsp_if.line_used !== exp_r.line_used) begin
            $error("line_used: expected %0d, got %0d", exp_r.line_used, rsp_if.line_used);
            err_cnt++;
          end
          if (rsp_if.miss_total !== exp_r.miss_total) begin
            $error("miss_total: expected %0d, got %0d", exp_r.miss_total, rsp_if.miss_total);
            err_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) pending_results.push_back(lfu_lookup(req_if.ref_tag));
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("No transaction for %0d cycles.", StallLimit);
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_ref(input logic [TagW-1:0] tag);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.ref_tag <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Builds a high use count on one line, then forces replacements in its set.
  // The heavily used line has to survive every one of those evictions.
  task automatic test_hot_line();
    logic [TagW-1:0] hot_tag;
    hot_tag       = TagW'($urandom);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    repeat (HotRefs) send_ref(hot_tag);
    repeat (5 * Sets) send_ref(TagW'($urandom));
    send_ref(hot_tag);
  endtask

  task automatic test_fill_and_evict();
    logic [TagW-1:0] dir_tags [21] = '{
      31'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0000, 31'h7FFF_FFFF, 31'h2AAA_AAAA,
      31'h5555_5555, 31'h2AAA_AAAA, 31'h0000_0001, 31'h4000_0000, 31'h0000_0000,
      31'h0000_0001, 31'h7FFF_FFFF, 31'h1234_5678, 31'h00FF_00FF, 31'h7F00_FF00,
      31'h5555_5555, 31'h0000_0000, 31'h0000_0003, 31'h0000_0005, 31'h0000_0006,
      31'h7FFF_FFFE
    };
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    foreach (dir_tags[k]) send_ref(dir_tags[k]);
  endtask

  // Mostly a small working set, so hits build uneven counts and the sets keep
  // evicting; fresh random tags and the extreme tags are mixed in.
  task automatic test_random_traffic(input int n_refs, input int src_pct, input int snk_pct);
    int pick;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (n_refs) begin
      pick = $urandom_range(99);
      if (pick < 40) send_ref(tag_pool[$urandom_range(HotSize - 1)]);
      else if (pick < 80) send_ref(tag_pool[$urandom_range(PoolSize - 1)]);
      else if (pick < 95) send_ref(TagW'($urandom));
      else if ($urandom_range(1) == 1) send_ref('1);
      else send_ref('0);
      if ($urandom_range(49) == 0) tag_pool[$urandom_range(PoolSize - 1)] = TagW'($urandom);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.ref_tag = '0;
    rsp_if.ready   = 1'b0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    err_cnt        = 0;
    ref_cnt        = 0;
    hit_cnt        = 0;
    stall_cycles   = 0;
    miss_cnt       = '0;
    fill_set       = 0;
    foreach (tag_pool[k]) tag_pool[k] = TagW'($urandom);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_hot_line();
    test_fill_and_evict();
    test_random_traffic(450, 0, 0);
    test_random_traffic(450, 75, 0);
    test_random_traffic(450, 0, 75);
    test_random_traffic(450, 20, 20);

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d references (%0d hits, %0d misses), including a heavily used line",
             ref_cnt, hit_cnt, miss_cnt);
    $display("under repeated evictions and random traffic with sender gaps and receiver stalls.");
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
